[hdl/distributed_dma_segmenter_assert.svh]
// Assertion macros used by the distributed DMA segmenter request sequencer.
`ifndef DISTRIBUTED_DMA_SEGMENTER_ASSERT_SVH
`define DISTRIBUTED_DMA_SEGMENTER_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define DDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define DDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dds_pkg.sv]
// Shared types and constants for the distributed DMA segmenter.
package dds_pkg;

    localparam int RANK_W  = 6;
    localparam int QUEUE_W = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_WRAP,
        S_SPAN,
        S_DIV,
        S_ROOM,
        S_EMIT,
        S_FAULT
    } seq_state_t;

    typedef struct packed {
        logic dir;
        logic fault;
        logic last;
    } chunk_flags_t;

endpackage

[hdl/dds_alu.sv]
// Shared compare-and-subtract unit: one restoring step per use.
module dds_alu #(
    parameter int W = 55
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic [W-1:0] keep,
    output logic         lt
);

    logic [W:0] wide;

    // Subtract with one extra bit so the borrow gives the compare
    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[W-1:0];
    assign lt   = wide[W];

    // Restore the minuend when the subtrahend does not fit
    assign keep = lt ? a : diff;

endmodule

[hdl/dds_seq.sv]
// Request sequencer: range checks, rank division and chunk generation.
`include "distributed_dma_segmenter_assert.svh"

module dds_seq
    import dds_pkg::*;
#(
    parameter int ADDR_BITS = 48,
    parameter int MAX_NODES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [ADDR_BITS-1:0] local_start,
    input  logic [ADDR_BITS-1:0] segment_base,
    input  logic [ADDR_BITS-1:0] global_offset,
    input  logic [ADDR_BITS-1:0] slice_bytes,
    input  logic [ADDR_BITS-1:0] byte_count,
    input  logic [QUEUE_W-1:0]   queue_number,
    input  logic                 slot_free,
    output logic                 emit,
    output chunk_flags_t         flags,
    output logic [ADDR_BITS-1:0] chunk_local,
    output logic [ADDR_BITS-1:0] chunk_remote,
    output logic [ADDR_BITS-1:0] chunk_length,
    output logic [RANK_W-1:0]    node_rank,
    output logic [QUEUE_W-1:0]   queue_out
);

    localparam int DIV_STEPS = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int W         = ADDR_BITS + DIV_STEPS + 1;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam logic [W-1:0] ADDR_SPAN = W'(1) << ADDR_BITS;

    seq_state_t             state_reg, state_next;
    logic                   dir_reg, dir_next;
    logic [ADDR_BITS-1:0]   loc_reg, loc_next;
    logic [ADDR_BITS-1:0]   base_reg, base_next;
    logic [ADDR_BITS-1:0]   off_reg, off_next;
    logic [ADDR_BITS-1:0]   slice_reg, slice_next;
    logic [ADDR_BITS-1:0]   amount_reg, amount_next;
    logic [QUEUE_W-1:0]     queue_reg, queue_next;
    logic [W-1:0]           sum_reg, sum_next;
    logic [W-1:0]           limit_reg, limit_next;
    logic [W-1:0]           rem_reg, rem_next;
    logic [W-1:0]           dvs_reg, dvs_next;
    logic [STEP_W-1:0]      cnt_reg, cnt_next;
    logic [RANK_W-1:0]      rank_reg, rank_next;
    logic [ADDR_BITS-1:0]   within_reg, within_next;
    logic [ADDR_BITS-1:0]   room_reg, room_next;

    logic [W-1:0]           alu_a, alu_b, alu_diff, alu_keep;
    logic                   alu_lt;
    logic [ADDR_BITS-1:0]   size_c;
    logic                   last_c;

    dds_alu #(
        .W (W)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .keep (alu_keep),
        .lt   (alu_lt)
    );

    // Chunk size and end of request, valid while issuing chunks
    assign size_c = alu_lt ? amount_reg : room_reg;
    assign last_c = alu_lt || (alu_diff == '0);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Request and working registers
    always_ff @(posedge clk)
    begin
        dir_reg    <= dir_next;
        loc_reg    <= loc_next;
        base_reg   <= base_next;
        off_reg    <= off_next;
        slice_reg  <= slice_next;
        amount_reg <= amount_next;
        queue_reg  <= queue_next;
        sum_reg    <= sum_next;
        limit_reg  <= limit_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        rank_reg   <= rank_next;
        within_reg <= within_next;
        room_reg   <= room_next;
    end

    // Next state, shared unit operands and chunk outputs
    always_comb
    begin
        state_next  = state_reg;
        dir_next    = dir_reg;
        loc_next    = loc_reg;
        base_next   = base_reg;
        off_next    = off_reg;
        slice_next  = slice_reg;
        amount_next = amount_reg;
        queue_next  = queue_reg;
        sum_next    = sum_reg;
        limit_next  = limit_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        cnt_next    = cnt_reg;
        rank_next   = rank_reg;
        within_next = within_reg;
        room_next   = room_reg;

        alu_a    = '0;
        alu_b    = '0;
        in_ready = 1'b0;
        emit     = 1'b0;

        flags.dir    = dir_reg;
        flags.fault  = 1'b0;
        flags.last   = last_c;
        chunk_local  = loc_reg;
        chunk_remote = base_reg + within_reg;
        chunk_length = size_c;
        node_rank    = rank_reg;
        queue_out    = queue_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Take a new request
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dir_next    = action;
                    loc_next    = local_start;
                    base_next   = segment_base;
                    off_next    = global_offset;
                    slice_next  = slice_bytes;
                    amount_next = byte_count;
                    queue_next  = queue_number;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                // Form end of span and end of the last node's slice
                sum_next   = W'(off_reg) + W'(amount_reg);
                limit_next = W'(slice_reg) * W'(MAX_NODES);
                if (amount_reg == '0)
                    state_next = S_IDLE;
                else if (slice_reg == '0)
                    state_next = S_FAULT;
                else
                    state_next = S_WRAP;
            end
            S_WRAP:
            begin
                // Reject a span that runs past the top of the address space
                alu_a = ADDR_SPAN;
                alu_b = sum_reg;
                state_next = alu_lt ? S_FAULT : S_SPAN;
            end
            S_SPAN:
            begin
                // Reject a span that reaches beyond the last node
                alu_a = limit_reg;
                alu_b = sum_reg;
                if (alu_lt)
                    state_next = S_FAULT;
                else
                begin
                    rem_next   = W'(off_reg);
                    dvs_next   = W'(slice_reg) << (DIV_STEPS - 1);
                    cnt_next   = STEP_W'(DIV_STEPS - 1);
                    rank_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // One quotient bit of the starting rank per cycle
                alu_a     = rem_reg;
                alu_b     = dvs_reg;
                rem_next  = alu_keep;
                rank_next = {rank_reg[RANK_W-2:0], ~alu_lt};
                dvs_next  = dvs_reg >> 1;
                if (cnt_reg == '0)
                    state_next = S_ROOM;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_ROOM:
            begin
                // Bytes left in the first node's slice
                alu_a       = W'(slice_reg);
                alu_b       = rem_reg;
                within_next = rem_reg[ADDR_BITS-1:0];
                room_next   = alu_diff[ADDR_BITS-1:0];
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                // Issue one chunk and advance to the next node boundary
                alu_a = W'(amount_reg);
                alu_b = W'(room_reg);
                if (slot_free)
                begin
                    emit        = 1'b1;
                    loc_next    = loc_reg + size_c;
                    amount_next = alu_lt ? '0 : alu_diff[ADDR_BITS-1:0];
                    rank_next   = rank_reg + 1'b1;
                    within_next = '0;
                    room_next   = slice_reg;
                    if (last_c)
                        state_next = S_IDLE;
                end
            end
            S_FAULT:
            begin
                // Issue the single error transaction
                flags.fault  = 1'b1;
                flags.last   = 1'b1;
                chunk_remote = base_reg;
                chunk_length = '0;
                node_rank    = '0;
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `DDS_ASSERT_NOW(a_emit_slot, emit, slot_free, "chunk issued into an occupied output slot")
    `DDS_ASSERT_NOW(a_fault_last, emit && flags.fault, flags.last, "error transaction not last")
    `DDS_ASSERT_NOW(a_len_nonzero, emit && !flags.fault, chunk_length != '0, "empty chunk issued")
    `DDS_ASSERT_NOW(a_rank_range, state_reg == S_EMIT, rank_reg <= RANK_W'(MAX_NODES - 1), "rank beyond last node")
    `DDS_ASSERT_NEXT(a_accept_prep, in_valid && in_ready, state_reg == S_PREP, "accepted request not prepared")

endmodule

[hdl/distributed_dma_segmenter.sv]
// Distributed DMA segmenter top level: request sequencer and output register.
//
//  channel   handshake            payload
//  request   in_valid/in_ready    action, local_start, segment_base, global_offset,
//                                 slice_bytes, byte_count, queue_number
//  chunk     out_valid/out_ready  direction, chunk_local, chunk_remote, chunk_length,
//                                 node_rank, queue_out, fault, last
//
// After acceptance come a prepare step, the range checks, the rank division and a room step,
// then one chunk per cycle while the output slot is free; checks, division and chunk issue
// share one compare-and-subtract unit. A zero byte count frees the sequencer from the prepare
// step; an error request frees it once the output register takes its error transaction.
// in_ready is high only while the sequencer is idle; one request is in flight at a time.
// A stalled output register holds its transaction and the sequencer waits on it.
// rst_n clears the sequencer state and the output valid flag asynchronously.
module distributed_dma_segmenter
    import dds_pkg::*;
#(
    parameter int ADDR_BITS = 48,
    parameter int MAX_NODES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [ADDR_BITS-1:0] local_start,
    input  logic [ADDR_BITS-1:0] segment_base,
    input  logic [ADDR_BITS-1:0] global_offset,
    input  logic [ADDR_BITS-1:0] slice_bytes,
    input  logic [ADDR_BITS-1:0] byte_count,
    input  logic [QUEUE_W-1:0]   queue_number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 direction,
    output logic [ADDR_BITS-1:0] chunk_local,
    output logic [ADDR_BITS-1:0] chunk_remote,
    output logic [ADDR_BITS-1:0] chunk_length,
    output logic [RANK_W-1:0]    node_rank,
    output logic [QUEUE_W-1:0]   queue_out,
    output logic                 fault,
    output logic                 last
);

    logic                 slot_free;
    logic                 emit;
    chunk_flags_t         seq_flags;
    logic [ADDR_BITS-1:0] seq_local, seq_remote, seq_length;
    logic [RANK_W-1:0]    seq_rank;
    logic [QUEUE_W-1:0]   seq_queue;

    logic                 out_valid_reg, out_valid_next;
    chunk_flags_t         flags_reg;
    logic [ADDR_BITS-1:0] local_reg, remote_reg, length_reg;
    logic [RANK_W-1:0]    rank_reg;
    logic [QUEUE_W-1:0]   queue_reg;

    dds_seq #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_NODES (MAX_NODES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .local_start   (local_start),
        .segment_base  (segment_base),
        .global_offset (global_offset),
        .slice_bytes   (slice_bytes),
        .byte_count    (byte_count),
        .queue_number  (queue_number),
        .slot_free     (slot_free),
        .emit          (emit),
        .flags         (seq_flags),
        .chunk_local   (seq_local),
        .chunk_remote  (seq_remote),
        .chunk_length  (seq_length),
        .node_rank     (seq_rank),
        .queue_out     (seq_queue)
    );

    // Slot is free when empty or when its transaction leaves this cycle
    assign slot_free      = !out_valid_reg || out_ready;
    assign out_valid_next = emit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Load the output register on each issued chunk
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            flags_reg  <= seq_flags;
            local_reg  <= seq_local;
            remote_reg <= seq_remote;
            length_reg <= seq_length;
            rank_reg   <= seq_rank;
            queue_reg  <= seq_queue;
        end
    end

    assign out_valid    = out_valid_reg;
    assign direction    = flags_reg.dir;
    assign fault        = flags_reg.fault;
    assign last         = flags_reg.last;
    assign chunk_local  = local_reg;
    assign chunk_remote = remote_reg;
    assign chunk_length = length_reg;
    assign node_rank    = rank_reg;
    assign queue_out    = queue_reg;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the distributed DMA segmenter: driver, chunk predictor, monitor.
module testbench;
    import dds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_BITS = 48;
    localparam int MAX_NODES = 64;
    localparam logic [63:0] SPACE = 64'd1 << ADDR_BITS;
    localparam logic [63:0] ADDR_MASK = SPACE - 64'd1;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int TAIL_CYCLES = 100;
    localparam int RANDOM_ITEMS = 230;

    typedef struct {
        logic                 act;
        logic [ADDR_BITS-1:0] loc;
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] off;
        logic [ADDR_BITS-1:0] slice;
        logic [ADDR_BITS-1:0] count;
        logic [QUEUE_W-1:0]   q;
        int                   gap;
        bit                   drain;
    } request_t;

    typedef struct packed {
        logic                 dir;
        logic [ADDR_BITS-1:0] loc;
        logic [ADDR_BITS-1:0] rem;
        logic [ADDR_BITS-1:0] len;
        logic [RANK_W-1:0]    rank;
        logic [QUEUE_W-1:0]   q;
        logic                 fault;
        logic                 last;
    } chunk_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [ADDR_BITS-1:0] local_start;
    logic [ADDR_BITS-1:0] segment_base;
    logic [ADDR_BITS-1:0] global_offset;
    logic [ADDR_BITS-1:0] slice_bytes;
    logic [ADDR_BITS-1:0] byte_count;
    logic [QUEUE_W-1:0]   queue_number;
    logic                 out_valid;
    logic                 out_ready;
    logic                 direction;
    logic [ADDR_BITS-1:0] chunk_local;
    logic [ADDR_BITS-1:0] chunk_remote;
    logic [ADDR_BITS-1:0] chunk_length;
    logic [RANK_W-1:0]    node_rank;
    logic [QUEUE_W-1:0]   queue_out;
    logic                 fault;
    logic                 last;

    request_t pending_requests[$];
    chunk_t   expected_chunks[$];

    int  cycle;
    int  requests_sent;
    int  requests_total;
    int  zero_count_sent;
    int  chunks_checked;
    int  faults_predicted;
    int  longest_split;
    int  mismatches;
    int  stall_left;
    bit  send_busy;
    bit  steady;
    chunk_t got_chunk;
    chunk_t want_chunk;

    distributed_dma_segmenter #(
        .ADDR_BITS(ADDR_BITS),
        .MAX_NODES(MAX_NODES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .local_start(local_start),
        .segment_base(segment_base),
        .global_offset(global_offset),
        .slice_bytes(slice_bytes),
        .byte_count(byte_count),
        .queue_number(queue_number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .direction(direction),
        .chunk_local(chunk_local),
        .chunk_remote(chunk_remote),
        .chunk_length(chunk_length),
        .node_rank(node_rank),
        .queue_out(queue_out),
        .fault(fault),
        .last(last)
    );

    // Random helpers
    function automatic logic [ADDR_BITS-1:0] rand_addr();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ADDR_BITS-1:0];
    endfunction

    function automatic logic [63:0] rand_below(input logic [63:0] n);
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v % n;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADDR_BITS-1:0] pick_slice();
        logic [ADDR_BITS-1:0] s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: s = ADDR_BITS'(1 + $urandom_range(0, 15));
            4, 5, 6:    s = ADDR_BITS'(1 + $urandom_range(0, 4095));
            7, 8:       s = 48'd1 + $urandom;
            default:    s = rand_addr();
        endcase
        if (s == 0)
            s = 1;
        return s;
    endfunction

    // Split one request into node-bounded chunks and queue them
    task automatic split_request(input request_t r);
        logic [63:0] off;
        logic [63:0] left;
        logic [63:0] slice;
        logic [63:0] loc;
        logic [63:0] rank;
        logic [63:0] slice_pos;
        logic [63:0] room;
        logic [63:0] size;
        chunk_t      c;
        chunk_t      batch[$];
        bit          bad;
        off   = 64'(r.off);
        left  = 64'(r.count);
        slice = 64'(r.slice);
        loc   = 64'(r.loc);
        if (left == 0)
        begin
            zero_count_sent++;
            return;
        end
        bad = (slice == 0) || (left - 1 > ADDR_MASK - off);
        while (!bad && left != 0)
        begin
            rank      = off / slice;
            slice_pos = off % slice;
            room      = slice - slice_pos;
            size      = (left < room) ? left : room;
            if (rank > MAX_NODES - 1 || batch.size() >= MAX_NODES)
                bad = 1'b1;
            else
            begin
                c.dir   = r.act;
                c.loc   = loc[ADDR_BITS-1:0];
                c.rem   = ADDR_BITS'((64'(r.base) + slice_pos) & ADDR_MASK);
                c.len   = size[ADDR_BITS-1:0];
                c.rank  = rank[RANK_W-1:0];
                c.q     = r.q;
                c.fault = 1'b0;
                c.last  = (left == size);
                batch.insert(batch.size(), c);
                loc  = (loc + size) & ADDR_MASK;
                off  = (off + size) & ADDR_MASK;
                left = left - size;
            end
        end
        if (bad)
        begin
            c.dir   = r.act;
            c.loc   = r.loc;
            c.rem   = r.base;
            c.len   = '0;
            c.rank  = '0;
            c.q     = r.q;
            c.fault = 1'b1;
            c.last  = 1'b1;
            expected_chunks.insert(expected_chunks.size(), c);
            faults_predicted++;
        end
        else
        begin
            foreach (batch[i])
                expected_chunks.insert(expected_chunks.size(), batch[i]);
            if (batch.size() > longest_split)
                longest_split = batch.size();
        end
    endtask

    task automatic add_request(input logic act, input logic [ADDR_BITS-1:0] loc,
                               input logic [ADDR_BITS-1:0] base,
                               input logic [ADDR_BITS-1:0] off,
                               input logic [ADDR_BITS-1:0] slice,
                               input logic [ADDR_BITS-1:0] count,
                               input logic [QUEUE_W-1:0] q, input bit drain);
        request_t r;
        r.act   = act;
        r.loc   = loc;
        r.base  = base;
        r.off   = off;
        r.slice = slice;
        r.count = count;
        r.q     = q;
        r.gap   = 0;
        r.drain = drain;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and run limit
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Driver: present pending requests, predict on each accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            send_busy = in_valid;
            if (in_valid && in_ready)
            begin
                split_request(pending_requests.pop_front());
                requests_sent++;
                send_busy = 1'b0;
            end
            if (!send_busy && pending_requests.size() > 0)
            begin
                if (pending_requests[0].gap > 0)
                    pending_requests[0].gap = pending_requests[0].gap - 1;
                else if (!(pending_requests[0].drain && expected_chunks.size() != 0))
                begin
                    action        <= pending_requests[0].act;
                    local_start   <= pending_requests[0].loc;
                    segment_base  <= pending_requests[0].base;
                    global_offset <= pending_requests[0].off;
                    slice_bytes   <= pending_requests[0].slice;
                    byte_count    <= pending_requests[0].count;
                    queue_number  <= pending_requests[0].q;
                    send_busy = 1'b1;
                end
            end
            in_valid <= send_busy;
        end
    end

    // Monitor: compare each accepted chunk with the oldest prediction, then pick out_ready
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                got_chunk = '{direction, chunk_local, chunk_remote, chunk_length,
                              node_rank, queue_out, fault, last};
                chunks_checked++;
                if (expected_chunks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected chunk: dir=%0b loc=%h rem=%h len=%h rank=%0d q=%0d fault=%0b last=%0b",
                                 got_chunk.dir, got_chunk.loc, got_chunk.rem, got_chunk.len,
                                 got_chunk.rank, got_chunk.q, got_chunk.fault, got_chunk.last);
                end
                else
                begin
                    want_chunk = expected_chunks.pop_front();
                    if (got_chunk.dir !== want_chunk.dir || got_chunk.loc !== want_chunk.loc ||
                        got_chunk.rem !== want_chunk.rem || got_chunk.len !== want_chunk.len ||
                        got_chunk.rank !== want_chunk.rank || got_chunk.q !== want_chunk.q ||
                        got_chunk.fault !== want_chunk.fault ||
                        got_chunk.last !== want_chunk.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("chunk %0d expected: dir=%0b loc=%h rem=%h len=%h rank=%0d q=%0d fault=%0b last=%0b",
                                     chunks_checked, want_chunk.dir, want_chunk.loc,
                                     want_chunk.rem, want_chunk.len, want_chunk.rank,
                                     want_chunk.q, want_chunk.fault, want_chunk.last);
                            $display("chunk %0d actual:   dir=%0b loc=%h rem=%h len=%h rank=%0d q=%0d fault=%0b last=%0b",
                                     chunks_checked, got_chunk.dir, got_chunk.loc,
                                     got_chunk.rem, got_chunk.len, got_chunk.rank,
                                     got_chunk.q, got_chunk.fault, got_chunk.last);
                        end
                    end
                end
            end
            // hold ready high through regular windows, stall at random elsewhere
            steady = ((cycle / 1500) % 5) == 0;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 25)
                    stall_left = idle_len();
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        request_t    r;
        logic [63:0] top;
        logic [63:0] span;
        logic [63:0] cap;
        int          kind;
        int          k;
        int          made;

        cycle            = 0;
        requests_sent    = 0;
        zero_count_sent  = 0;
        chunks_checked   = 0;
        faults_predicted = 0;
        longest_split    = 0;
        mismatches       = 0;
        stall_left       = 0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        out_ready        = 1'b0;
        action           = 1'b0;
        local_start      = '0;
        segment_base     = '0;
        global_offset    = '0;
        slice_bytes      = '0;
        byte_count       = '0;
        queue_number     = '0;

        // Directed: zero count, zero slice, node and address-space edges, wrapping outputs
        add_request(1'b0, rand_addr(), rand_addr(), 48'd100, 48'd10, 48'd0, 8'd0, 1'b0);
        add_request(1'b1, rand_addr(), rand_addr(), 48'd5, 48'd0, 48'd7, 8'd255, 1'b0);
        add_request(1'b0, 48'd0, 48'd0, 48'd0, 48'd1, 48'd1, 8'd0, 1'b0);
        add_request(1'b1, ADDR_MASK[47:0], ADDR_MASK[47:0], 48'd0, 48'd1, 48'd64,
                    8'd255, 1'b0);
        add_request(1'b0, rand_addr(), rand_addr(), 48'd0, 48'd1, 48'd65, 8'd1, 1'b0);
        add_request(1'b1, rand_addr(), rand_addr(), 48'd63, 48'd1, 48'd1, 8'd2, 1'b0);
        add_request(1'b0, rand_addr(), rand_addr(), 48'd64, 48'd1, 48'd1, 8'd3, 1'b0);
        add_request(1'b1, rand_addr(), rand_addr(), ADDR_MASK[47:0], ADDR_MASK[47:0],
                    48'd2, 8'd4, 1'b0);
        add_request(1'b0, rand_addr(), rand_addr(), ADDR_MASK[47:0], ADDR_MASK[47:0],
                    48'd1, 8'd5, 1'b0);
        add_request(1'b1, rand_addr(), rand_addr(), 48'd0, ADDR_MASK[47:0],
                    ADDR_MASK[47:0], 8'd6, 1'b0);
        add_request(1'b0, rand_addr(), rand_addr(), 48'd1, ADDR_MASK[47:0],
                    ADDR_MASK[47:0], 8'd7, 1'b0);
        add_request(1'b1, rand_addr(), rand_addr(), 48'd2, ADDR_MASK[47:0],
                    ADDR_MASK[47:0], 8'd8, 1'b0);
        add_request(1'b0, rand_addr(), ADDR_MASK[47:0], 48'd500, 48'd1000, 48'd1000,
                    8'd9, 1'b0);
        add_request(1'b1, ADDR_MASK[47:0] - 48'd9, rand_addr(), 48'd990, 48'd1000,
                    48'd20, 8'd10, 1'b0);
        add_request(1'b0, rand_addr(), rand_addr(), 48'd3000, 48'd1000, 48'd1000,
                    8'd11, 1'b0);
        add_request(1'b1, rand_addr(), rand_addr(), 48'd0, 48'd1 << 42, ADDR_MASK[47:0],
                    8'd12, 1'b0);
        add_request(1'b0, rand_addr(), rand_addr(), 48'd0, (48'd1 << 42) - 48'd1,
                    ADDR_MASK[47:0], 8'd13, 1'b0);
        add_request(1'b1, rand_addr(), rand_addr(), 48'd0, ADDR_MASK[47:0], 48'd0,
                    8'd14, 1'b0);
        add_request(1'b0, rand_addr(), rand_addr(), rand_addr(), 48'd0, ADDR_MASK[47:0],
                    8'd15, 1'b0);
        add_request(1'b1, rand_addr(), rand_addr(), 48'd17, 48'd8, 48'd40,
                    8'($urandom), 1'b1);

        // Random: mostly well-formed splits, the rest faults and noise
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            r.act   = 1'($urandom_range(0, 1));
            r.loc   = rand_addr();
            r.base  = rand_addr();
            r.q     = 8'($urandom);
            r.drain = (made % 40 == 0);
            r.gap   = (made >= 100 && made < 140) ? 0 : idle_len();
            kind    = $urandom_range(0, 99);
            r.slice = pick_slice();
            top     = 64'(r.slice) * MAX_NODES;
            if (top > SPACE)
                top = SPACE;
            if (kind < 70)
            begin
                k = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 64) : $urandom_range(1, 4);
                if (k > 4)
                    r.off = ADDR_BITS'(rand_below(64'(r.slice)));
                else
                    r.off = ADDR_BITS'(rand_below(top));
                cap  = top - 64'(r.off);
                span = 64'(r.slice) * k;
                if (span < cap)
                    cap = span;
                r.count = ADDR_BITS'(($urandom_range(0, 4) == 0) ? cap
                                                                 : 64'd1 + rand_below(cap));
            end
            else if (kind < 78)
            begin
                // run past the last node
                span = 64'(r.slice) * 4;
                if (span > top)
                    span = top;
                r.off   = ADDR_BITS'(top - 64'd1 - rand_below(span));
                r.count = ADDR_BITS'((top - 64'(r.off) + 64'd1 + rand_below(span)) & ADDR_MASK);
            end
            else if (kind < 84)
            begin
                // run past the end of the address space
                r.off   = ADDR_BITS'(ADDR_MASK - rand_below(64'd4096));
                r.count = ADDR_BITS'(SPACE - 64'(r.off) + 64'd1 + rand_below(64'd4096));
            end
            else if (kind < 88)
            begin
                r.off   = rand_addr();
                r.slice = '0;
                r.count = ADDR_BITS'(64'd1 + rand_below(64'd1000));
            end
            else if (kind < 92)
            begin
                r.off   = rand_addr();
                r.count = '0;
            end
            else
            begin
                r.off   = rand_addr();
                r.slice = rand_addr();
                r.count = rand_addr();
            end
            pending_requests.insert(pending_requests.size(), r);
            if (r.count != 0)
                made++;
        end
        requests_total = pending_requests.size();

        // Reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every chunk to arrive
        while (requests_sent != requests_total || expected_chunks.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        mismatches += expected_chunks.size();

        $display("Sent %0d requests (%0d with zero count), checked %0d chunks.",
                 requests_sent, zero_count_sent, chunks_checked);
        $display("Predicted %0d fault results; longest split was %0d chunks.",
                 faults_predicted, longest_split);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
